/* src/bps_pkg.sv */
// Shared types and constants for the primitive value serializer.
package bps_pkg;

  // Input item kinds.
  localparam logic [3:0] KIND_UNIT    = 4'd0;
  localparam logic [3:0] KIND_BOOL    = 4'd1;
  localparam logic [3:0] KIND_BYTE    = 4'd2;
  localparam logic [3:0] KIND_NAT0    = 4'd3;
  localparam logic [3:0] KIND_INT     = 4'd4;
  localparam logic [3:0] KIND_LE16    = 4'd5;
  localparam logic [3:0] KIND_LE32    = 4'd6;
  localparam logic [3:0] KIND_LE64    = 4'd7;
  localparam logic [3:0] KIND_BE16    = 4'd8;
  localparam logic [3:0] KIND_BE32    = 4'd9;
  localparam logic [3:0] KIND_BE64    = 4'd10;
  localparam logic [3:0] KIND_VARIANT = 4'd11;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_NEG   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_TWO   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_FOUR  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_EIGHT = 8'd3;

  // Prefix code reset values.
  localparam logic [7:0] CODE_NEG_RST   = 8'd255;
  localparam logic [7:0] CODE_TWO_RST   = 8'd254;
  localparam logic [7:0] CODE_FOUR_RST  = 8'd253;
  localparam logic [7:0] CODE_EIGHT_RST = 8'd252;

  // Longest encoding is a prefix byte plus eight data bytes.
  localparam int unsigned MAX_BYTES   = 9;
  localparam int unsigned BYTE_CNT_W  = 4;

  // Queue between classifier and serializer.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // One classified item: bytes in stream order (byte 0 first) and their count.
  typedef struct packed {
    logic [8*MAX_BYTES-1:0] bytes;
    logic [BYTE_CNT_W-1:0]  cnt;
  } desc_t;

endpackage

/* src/binary_primitive_serializer.sv */
// Top level of the primitive value serializer.
// Each item is a kind tag and a 64-bit value; the block emits the value's
// serialized bytes as output items, one byte per cycle while out_stall is
// low, with last set on the final byte. An encoding is 1 to 9 bytes long:
// one byte for unit, bool, byte and small non-negative integers, up to nine
// for a prefixed 64-bit integer. The byte serializer, which shifts one byte
// per cycle into the output register while it is not stalled, sets the
// sustained rate. The front end classifies an item in the cycle it is
// accepted and places it in a two-entry queue, so new items are taken while
// earlier ones are still being shifted out. Items of kinds 12 to 15 are
// accepted and produce no output. Configuration writes are always ready and
// take effect on the next cycle; writes to indexes above 3 are ignored.
module binary_primitive_serializer import bps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic  q_full, q_empty, q_push, q_pop;
  desc_t q_push_desc, q_pop_desc;

  // Classifier and configuration registers.
  bps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (q_push),
    .push_desc (q_push_desc)
  );

  // Decoupling queue.
  bps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_push_desc),
    .pop       (q_pop),
    .pop_desc  (q_pop_desc),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Byte serializer and output register.
  bps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_desc    (q_pop_desc),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

/* src/bps_front.sv */
// Front end: accepts items, holds the prefix codes and builds byte descriptors.
module bps_front import bps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 q_full,
  output logic                 push,
  output desc_t                push_desc
);

  logic [7:0]  code_neg_r, code_two_r, code_four_r, code_eight_r;
  logic [7:0]  code_neg_nxt, code_two_nxt, code_four_nxt, code_eight_nxt;
  logic        kind_known;
  logic [63:0] v;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign v         = in_item.value;

  // Configuration writes; indexes beyond the list are ignored.
  always_comb begin
    code_neg_nxt   = code_neg_r;
    code_two_nxt   = code_two_r;
    code_four_nxt  = code_four_r;
    code_eight_nxt = code_eight_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_CODE_NEG:   code_neg_nxt   = cfg_data;
        REG_CODE_TWO:   code_two_nxt   = cfg_data;
        REG_CODE_FOUR:  code_four_nxt  = cfg_data;
        REG_CODE_EIGHT: code_eight_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_neg_r   <= CODE_NEG_RST;
      code_two_r   <= CODE_TWO_RST;
      code_four_r  <= CODE_FOUR_RST;
      code_eight_r <= CODE_EIGHT_RST;
    end else begin
      code_neg_r   <= code_neg_nxt;
      code_two_r   <= code_two_nxt;
      code_four_r  <= code_four_nxt;
      code_eight_r <= code_eight_nxt;
    end
  end

  // Classify the item and lay out its bytes in stream order.
  always_comb begin
    push_desc  = '0;
    kind_known = 1'b1;
    case (in_item.kind)
      KIND_UNIT: begin
        push_desc.cnt = 4'd1;
      end
      KIND_BOOL: begin
        push_desc.bytes = {64'h0, 7'h0, |v};
        push_desc.cnt   = 4'd1;
      end
      KIND_BYTE: begin
        push_desc.bytes = {64'h0, v[7:0]};
        push_desc.cnt   = 4'd1;
      end
      KIND_NAT0: begin
        if (v[63:7] == '0) begin
          push_desc.bytes = {64'h0, v[7:0]};
          push_desc.cnt   = 4'd1;
        end else if (v[63:16] == '0) begin
          push_desc.bytes = {v, code_two_r};
          push_desc.cnt   = 4'd3;
        end else if (v[63:32] != '0) begin
          push_desc.bytes = {v, code_eight_r};
          push_desc.cnt   = 4'd9;
        end else begin
          push_desc.bytes = {v, code_four_r};
          push_desc.cnt   = 4'd5;
        end
      end
      KIND_INT: begin
        if (!v[63]) begin
          // Non-negative values.
          if (v[63:7] == '0) begin
            push_desc.bytes = {64'h0, v[7:0]};
            push_desc.cnt   = 4'd1;
          end else if (v[63:15] == '0) begin
            push_desc.bytes = {v, code_two_r};
            push_desc.cnt   = 4'd3;
          end else if (v[63:31] != '0) begin
            push_desc.bytes = {v, code_eight_r};
            push_desc.cnt   = 4'd9;
          end else begin
            push_desc.bytes = {v, code_four_r};
            push_desc.cnt   = 4'd5;
          end
        end else begin
          // Negative values: bands follow the sign-extension width.
          if (v[63:7] == '1) begin
            push_desc.bytes = {v, code_neg_r};
            push_desc.cnt   = 4'd2;
          end else if (v[63:15] == '1) begin
            push_desc.bytes = {v, code_two_r};
            push_desc.cnt   = 4'd3;
          end else if (v[63:31] != '1) begin
            push_desc.bytes = {v, code_eight_r};
            push_desc.cnt   = 4'd9;
          end else begin
            push_desc.bytes = {v, code_four_r};
            push_desc.cnt   = 4'd5;
          end
        end
      end
      KIND_LE16: begin
        push_desc.bytes = {8'h0, v};
        push_desc.cnt   = 4'd2;
      end
      KIND_LE32: begin
        push_desc.bytes = {8'h0, v};
        push_desc.cnt   = 4'd4;
      end
      KIND_LE64: begin
        push_desc.bytes = {8'h0, v};
        push_desc.cnt   = 4'd8;
      end
      KIND_BE16: begin
        push_desc.bytes = {56'h0, v[7:0], v[15:8]};
        push_desc.cnt   = 4'd2;
      end
      KIND_BE32: begin
        push_desc.bytes = {40'h0, v[7:0], v[15:8], v[23:16], v[31:24]};
        push_desc.cnt   = 4'd4;
      end
      KIND_BE64: begin
        push_desc.bytes = {8'h0, v[7:0], v[15:8], v[23:16], v[31:24],
                           v[39:32], v[47:40], v[55:48], v[63:56]};
        push_desc.cnt   = 4'd8;
      end
      KIND_VARIANT: begin
        push_desc.bytes = {40'h0, v[30:0], 1'b1};
        push_desc.cnt   = 4'd4;
      end
      default: begin
        kind_known = 1'b0;
      end
    endcase
  end

  // Items of an unused kind are accepted and produce nothing.
  assign push = in_valid & ~q_full & kind_known;

endmodule

/* src/bps_queue.sv */
// Small queue of byte descriptors between the front end and the serializer.
module bps_queue import bps_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  input  logic  pop,
  output desc_t pop_desc,
  output logic  full,
  output logic  empty
);

  desc_t              slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_desc = slot_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Slot storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

/* src/bps_back.sv */
// Back end: one byte per cycle unless stalled, into a registered output.
module bps_back import bps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  desc_t     q_desc,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic                   busy_r, busy_nxt;
  logic [8*MAX_BYTES-1:0] bytes_r, bytes_nxt;
  logic [BYTE_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_item_r, out_item_nxt;
  logic                   advance;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // The output stage moves when it is empty or its item is taken.
  assign advance = ~out_valid_r | ~out_stall;
  assign pop     = advance & ~busy_r & ~q_empty;

  always_comb begin
    busy_nxt      = busy_r;
    bytes_nxt     = bytes_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (advance) begin
      if (busy_r) begin
        // Continue the item in progress.
        out_valid_nxt         = 1'b1;
        out_item_nxt.out_byte = bytes_r[7:0];
        out_item_nxt.last     = (cnt_r == BYTE_CNT_W'(1));
        bytes_nxt             = bytes_r >> 8;
        cnt_nxt               = cnt_r - 1'b1;
        busy_nxt              = (cnt_r != BYTE_CNT_W'(1));
      end else if (!q_empty) begin
        // Start the next queued item.
        out_valid_nxt         = 1'b1;
        out_item_nxt.out_byte = q_desc.bytes[7:0];
        out_item_nxt.last     = (q_desc.cnt == BYTE_CNT_W'(1));
        bytes_nxt             = q_desc.bytes >> 8;
        cnt_nxt               = q_desc.cnt - 1'b1;
        busy_nxt              = (q_desc.cnt != BYTE_CNT_W'(1));
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    bytes_r    <= bytes_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule
